@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the LED group pattern generator.
// Standalone header; no dependencies. Bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define LGPG_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define LGPG_ASSERT_NXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define LGPG_ASSERT_IMP(label, clk, rstn, pre, post)
`define LGPG_ASSERT_NXT(label, clk, rstn, pre, post)
`endif

`endif

@@ hw/rtl/lgpg_pkg.sv @@
// Types, constants and helper functions of the LED group pattern generator.
// No dependencies; imported by the controller, the datapath and the top level.
package lgpg_pkg;

    typedef enum logic [2:0] {
        MODE_OFF    = 3'd0,
        MODE_SOLID  = 3'd1,
        MODE_FLASH  = 3'd2,
        MODE_WAVE   = 3'd3,
        MODE_BOUNCE = 3'd4,
        MODE_RANDOM = 3'd5,
        MODE_BAR    = 3'd6,
        MODE_FILL   = 3'd7
    } mode_t;

    // configuration register indexes
    localparam logic [2:0] CFG_MODE   = 3'd0;
    localparam logic [2:0] CFG_COLOR  = 3'd1;
    localparam logic [2:0] CFG_GROUP  = 3'd2;
    localparam logic [2:0] CFG_STEP   = 3'd3;
    localparam logic [2:0] CFG_HOLD   = 3'd4;
    localparam logic [2:0] CFG_OFFSET = 3'd5;
    localparam logic [2:0] CFG_SPAN   = 3'd6;
    localparam logic [2:0] CFG_MIRROR = 3'd7;

    localparam int CFG_DATA_W = 24;
    localparam int MS_W       = 20;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;

    localparam logic [MS_W-1:0] TICK_MS    = 20'd10;
    localparam logic [MS_W-1:0] MS_MAX     = 20'hFFFFF;
    localparam logic [15:0]     LFSR_SEED  = 16'hACE1;
    // remainder unit: phase < 64, so six restoring steps, shift 5 down to 0
    localparam logic [2:0]      MOD_TOP    = 3'd5;
    localparam logic [1:0]      RGB_TOP    = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       mod_step;
        logic [2:0] mod_shift;
        logic       plan;
        logic       update;
        logic       rand_step;
        logic       emit;
    } lgpg_cmd_t;

    typedef struct packed {
        logic rand_mode;
        logic empty;
        logic last;
        logic out_free;
    } lgpg_sts_t;

    // eight shifts of the Fibonacci LFSR, taps 16 14 13 11, shifting right
    function automatic logic [15:0] lfsr_adv8(input logic [15:0] seed);
        logic [15:0] l;
        logic        fb;
        l = seed;
        for (int k = 0; k < 8; k++) begin
            fb = l[0] ^ l[2] ^ l[3] ^ l[5];
            l  = {fb, l[15:1]};
        end
        return l;
    endfunction

endpackage

@@ hw/rtl/lgpg_ctrl.sv @@
// Sequencing controller of the LED group pattern generator.
// Depends on lgpg_pkg for the command and status structs.
module lgpg_ctrl
    import lgpg_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  lgpg_sts_t sts,
    output lgpg_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_PLAN,
        ST_UPDATE,
        ST_RGEN,
        ST_EMIT
    } state_t;

    state_t      state_reg, state_next;
    logic [2:0]  mod_cnt_reg, mod_cnt_next;
    logic [1:0]  rgb_cnt_reg, rgb_cnt_next;
    logic        ready_reg, ready_next;

    assign s_tready = ready_reg;

    always_comb begin
        state_next   = state_reg;
        mod_cnt_next = mod_cnt_reg;
        rgb_cnt_next = rgb_cnt_reg;
        ready_next   = ready_reg;
        cmd          = '0;
        cmd.mod_shift = mod_cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && ready_reg) begin
                    cmd.accept   = 1'b1;
                    ready_next   = 1'b0;
                    mod_cnt_next = MOD_TOP;
                    state_next   = ST_MOD;
                end
            end
            ST_MOD: begin
                cmd.mod_step = 1'b1;
                if (mod_cnt_reg == 3'd0) begin
                    state_next = ST_PLAN;
                end else begin
                    mod_cnt_next = mod_cnt_reg - 3'd1;
                end
            end
            ST_PLAN: begin
                cmd.plan   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update   = 1'b1;
                rgb_cnt_next = 2'd0;
                if (sts.empty) begin
                    ready_next = 1'b1;
                    state_next = ST_IDLE;
                end else if (sts.rand_mode) begin
                    state_next = ST_RGEN;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_RGEN: begin
                cmd.rand_step = 1'b1;
                if (rgb_cnt_reg == RGB_TOP) begin
                    state_next = ST_EMIT;
                end else begin
                    rgb_cnt_next = rgb_cnt_reg + 2'd1;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.last) begin
                        ready_next = 1'b1;
                        state_next = ST_IDLE;
                    end else if (sts.rand_mode) begin
                        rgb_cnt_next = 2'd0;
                        state_next   = ST_RGEN;
                    end
                end
            end
            default: begin
                ready_next = 1'b1;
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mod_cnt_reg <= 3'd0;
            rgb_cnt_reg <= 2'd0;
            ready_reg   <= 1'b1;
        end else begin
            state_reg   <= state_next;
            mod_cnt_reg <= mod_cnt_next;
            rgb_cnt_reg <= rgb_cnt_next;
            ready_reg   <= ready_next;
        end
    end

endmodule

@@ hw/rtl/lgpg_dp.sv @@
// Datapath of the LED group pattern generator: configuration registers,
// timing state, LFSR, emission cursor and output register. Uses lgpg_pkg.
module lgpg_dp
    import lgpg_pkg::*;
#(
    parameter int LED_LIMIT = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [2:0]             cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                   restart,
    input  lgpg_cmd_t              cmd,
    output lgpg_sts_t              sts,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast
);

    localparam logic [5:0] LIM = 6'(LED_LIMIT);

    // configuration
    mode_t            mode_reg;
    logic [23:0]      color_reg;
    logic [5:0]       group_reg;
    logic [MS_W-1:0]  step_reg, hold_reg, offset_reg;
    logic [7:0]       span_reg;
    logic             mirror_reg;

    // timing state
    logic [MS_W-1:0]  elapsed_reg, elapsed_next;
    logic [5:0]       phase_reg, phase_next;
    logic             bback_reg, bback_next;
    logic [15:0]      lfsr_reg;
    logic [5:0]       mod_reg, mod_next;

    // emission plan
    logic [5:0]       cursor_reg, remain_reg;
    logic             mir_reg, wrap_reg, rand_reg;
    logic [MS_W-1:0]  e10_reg;
    logic [MS_W:0]    sum_reg;
    logic [23:0]      rcol_reg;

    // output register
    logic             m_valid_reg;
    logic [4:0]       m_index_reg;
    logic [23:0]      m_color_reg;
    logic             m_last_reg;

    logic [5:0]       n, w;
    logic [11:0]      divisor;
    logic             flash_lit, ge_step;
    logic [5:0]       plan_start, plan_cnt, room;
    logic             plan_mir, plan_wrap;
    logic [MS_W:0]    e10_wide;
    logic [MS_W-1:0]  e10;
    logic [5:0]       minc;
    logic [6:0]       positions;
    logic [15:0]      lfsr_adv;
    logic [15:0]      prod;
    logic [5:0]       cursor_inc, cursor_next, mir_index;

    // effective group size and width
    always_comb begin
        if (group_reg == 6'd0) begin
            n = 6'd1;
        end else if (group_reg > LIM) begin
            n = LIM;
        end else begin
            n = group_reg;
        end
        w = (span_reg < {2'b00, n}) ? span_reg[5:0] : n;
    end

    // restoring remainder step: phase mod n
    assign divisor = {6'd0, n} << cmd.mod_shift;

    always_comb begin
        mod_next = mod_reg;
        if (cmd.accept) begin
            mod_next = restart ? 6'd0 : phase_reg;
        end else if (cmd.mod_step && ({6'd0, mod_reg} >= divisor)) begin
            mod_next = mod_reg - divisor[5:0];
        end
    end

    // plan of this tick from the pre-update state
    assign flash_lit = (elapsed_reg >= offset_reg) &&
                       ({1'b0, elapsed_reg} < ({1'b0, offset_reg} + {1'b0, step_reg}));
    assign ge_step   = elapsed_reg >= step_reg;
    assign room      = n - phase_reg;

    always_comb begin
        plan_start = 6'd0;
        plan_cnt   = 6'd0;
        plan_mir   = mirror_reg;
        plan_wrap  = 1'b0;
        case (mode_reg)
            MODE_SOLID:  plan_cnt = n;
            MODE_FLASH:  plan_cnt = flash_lit ? n : 6'd0;
            MODE_WAVE: begin
                plan_start = mod_reg;
                plan_cnt   = w;
                plan_wrap  = 1'b1;
            end
            MODE_BOUNCE: begin
                plan_start = phase_reg;
                plan_mir   = 1'b0;
                if (phase_reg < n) begin
                    plan_cnt = (w < room) ? w : room;
                end
            end
            MODE_RANDOM: begin
                plan_mir = 1'b0;
                plan_cnt = ge_step ? n : 6'd0;
            end
            MODE_BAR:    plan_cnt = w;
            MODE_FILL:   plan_cnt = (phase_reg <= n) ? phase_reg : n;
            default:     plan_cnt = 6'd0;
        endcase
    end

    assign e10_wide  = {1'b0, elapsed_reg} + {1'b0, TICK_MS};
    assign e10       = e10_wide[MS_W] ? MS_MAX : e10_wide[MS_W-1:0];
    assign minc      = mod_reg + 6'd1;
    assign positions = {1'b0, n} - {1'b0, w} + 7'd1;

    // timing state update
    always_comb begin
        elapsed_next = elapsed_reg;
        phase_next   = phase_reg;
        bback_next   = bback_reg;
        if (cmd.accept) begin
            if (restart) begin
                elapsed_next = '0;
                phase_next   = 6'd0;
            end
        end else if (cmd.update) begin
            case (mode_reg)
                MODE_FLASH: begin
                    elapsed_next = ({1'b0, e10_reg} >= sum_reg) ? '0 : e10_reg;
                end
                MODE_WAVE: begin
                    if (ge_step) begin
                        elapsed_next = '0;
                        phase_next   = (minc == n) ? 6'd0 : minc;
                    end else begin
                        elapsed_next = e10_reg;
                    end
                end
                MODE_BOUNCE: begin
                    if (ge_step) begin
                        elapsed_next = '0;
                        if (positions <= 7'd1) begin
                            phase_next = 6'd0;
                        end else if (!bback_reg) begin
                            if (({1'b0, phase_reg} + 7'd1) >= positions) begin
                                bback_next = 1'b1;
                                if (phase_reg != 6'd0) begin
                                    phase_next = phase_reg - 6'd1;
                                end
                            end else begin
                                phase_next = phase_reg + 6'd1;
                            end
                        end else if (phase_reg == 6'd0) begin
                            phase_next = 6'd1;
                            bback_next = 1'b0;
                        end else begin
                            phase_next = phase_reg - 6'd1;
                        end
                    end else begin
                        elapsed_next = e10_reg;
                    end
                end
                MODE_RANDOM: begin
                    elapsed_next = ge_step ? '0 : e10_reg;
                end
                MODE_FILL: begin
                    if (phase_reg <= n) begin
                        if (ge_step) begin
                            elapsed_next = '0;
                            phase_next   = phase_reg + 6'd1;
                        end else begin
                            elapsed_next = e10_reg;
                        end
                    end else if (elapsed_reg >= hold_reg) begin
                        elapsed_next = '0;
                        phase_next   = 6'd0;
                    end else begin
                        elapsed_next = e10_reg;
                    end
                end
                default: ;
            endcase
        end
        if (cfg_wr_en && (cfg_wr_index == CFG_MIRROR)) begin
            bback_next = cfg_wr_data[0];
        end
    end

    // configuration and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_OFF;
            color_reg   <= '0;
            group_reg   <= 6'd1;
            step_reg    <= '0;
            hold_reg    <= '0;
            offset_reg  <= '0;
            span_reg    <= '0;
            mirror_reg  <= 1'b0;
            elapsed_reg <= '0;
            phase_reg   <= 6'd0;
            bback_reg   <= 1'b0;
            lfsr_reg    <= LFSR_SEED;
            remain_reg  <= 6'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_MODE:   mode_reg   <= mode_t'(cfg_wr_data[2:0]);
                    CFG_COLOR:  color_reg  <= cfg_wr_data[23:0];
                    CFG_GROUP:  group_reg  <= cfg_wr_data[5:0];
                    CFG_STEP:   step_reg   <= cfg_wr_data[MS_W-1:0];
                    CFG_HOLD:   hold_reg   <= cfg_wr_data[MS_W-1:0];
                    CFG_OFFSET: offset_reg <= cfg_wr_data[MS_W-1:0];
                    CFG_SPAN:   span_reg   <= cfg_wr_data[7:0];
                    CFG_MIRROR: mirror_reg <= cfg_wr_data[0];
                    default: ;
                endcase
            end
            elapsed_reg <= elapsed_next;
            phase_reg   <= phase_next;
            bback_reg   <= bback_next;
            if (cmd.rand_step) begin
                lfsr_reg <= lfsr_adv;
            end
            if (cmd.plan) begin
                remain_reg <= plan_cnt;
            end else if (cmd.emit) begin
                remain_reg <= remain_reg - 6'd1;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // random colour: one channel per step, red first
    assign lfsr_adv = lfsr_adv8(lfsr_reg);
    assign prod     = {8'd0, lfsr_adv[7:0]} * {8'd0, span_reg};

    assign cursor_inc  = cursor_reg + 6'd1;
    assign cursor_next = (wrap_reg && (cursor_inc == n)) ? 6'd0 : cursor_inc;
    assign mir_index   = mir_reg ? (n - 6'd1 - cursor_reg) : cursor_reg;

    // payload
    always_ff @(posedge aclk) begin
        mod_reg <= mod_next;
        if (cmd.plan) begin
            cursor_reg <= plan_start;
            mir_reg    <= plan_mir;
            wrap_reg   <= plan_wrap;
            rand_reg   <= (mode_reg == MODE_RANDOM);
            e10_reg    <= e10;
            sum_reg    <= {1'b0, step_reg} + {1'b0, hold_reg};
        end else if (cmd.emit) begin
            cursor_reg <= cursor_next;
        end
        if (cmd.rand_step) begin
            rcol_reg <= {rcol_reg[15:0], prod[15:8]};
        end
        if (cmd.emit) begin
            m_index_reg <= mir_index[4:0];
            m_color_reg <= rand_reg ? rcol_reg : color_reg;
            m_last_reg  <= (remain_reg == 6'd1);
        end
    end

    assign sts.rand_mode = rand_reg;
    assign sts.empty     = (remain_reg == 6'd0);
    assign sts.last      = (remain_reg == 6'd1);
    assign sts.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_color_reg, m_index_reg};
    assign m_tlast  = m_last_reg;

endmodule

@@ hw/rtl/led_group_pattern_generator.sv @@
// Top level of the LED group pattern generator: controller plus datapath.
// Depends on lgpg_pkg, lgpg_ctrl, lgpg_dp and assert_macros.svh.
//
//  channel  direction  handshake            payload
//  s_       in         s_tvalid / s_tready  s_tdata[0] restart (one 10 ms tick)
//  m_       out        m_tvalid / m_tready  m_tdata led_index, led_color; m_tlast
//  cfg_     in         cfg_wr_en            cfg_wr_index, cfg_wr_data
//
// A tick runs through the accept state, the remainder steps, the plan and the update state,
// then makes the LED writes, one per cycle outside random mode while the m_ side takes them.
// In random mode the LFSR/multiplier steps that build a colour come before each LED write.
// Reset is synchronous and active low; no clearing pass follows it.
// A stalled m_ side holds the write in the output register and pauses the
// sequence; the next tick is accepted as soon as the last write is registered.
module led_group_pattern_generator
    import lgpg_pkg::*;
#(
    parameter int MAX_LEDS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration
    input  logic                   cfg_wr_en,
    input  logic [2:0]             cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    // tick stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] restart, [7:1] zero
    // LED write stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [4:0] led_index, [28:5] led_color
    output logic                   m_tlast
);

`include "assert_macros.svh"

    // hardware never drives more than 32 LEDs per group
    localparam int LED_LIMIT = (MAX_LEDS < 32) ? MAX_LEDS : 32;

    lgpg_cmd_t  cmd;
    lgpg_sts_t  sts;
    logic       s_accept;
    logic [5:0] cmd_strobes;

    assign s_accept    = s_tvalid && s_tready;
    assign cmd_strobes = {cmd.accept, cmd.mod_step, cmd.plan,
                          cmd.update, cmd.rand_step, cmd.emit};

    // sequence the tick: remainder, plan, update, then the writes
    lgpg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // hold configuration, timing state and the output register
    lgpg_dp #(
        .LED_LIMIT (LED_LIMIT)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .restart      (s_tdata[0]),
        .cmd          (cmd),
        .sts          (sts),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

    // drop ready for the whole tick once a transaction is taken
`LGPG_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_accept, !s_tready)
    // a registered write always shows on the master side
`LGPG_ASSERT_NXT(a_emit_shows, aclk, aresetn, cmd.emit, m_tvalid)
    // the final write of a tick frees the slave side
`LGPG_ASSERT_NXT(a_last_frees, aclk, aresetn, cmd.emit && sts.last, s_tready)
    // at most one datapath command per cycle
`LGPG_ASSERT_IMP(a_one_cmd, aclk, aresetn, 1'b1, $onehot0(cmd_strobes))

endmodule

@@ tb/led_group_pattern_generator_test.sv @@
// Self-checking testbench for the LED group pattern generator.
// Needs only lgpg_pkg and the RTL of led_group_pattern_generator; reads no files.
// Predicts every LED write per tick and checks the m_ stream field by field.
`timescale 1ns / 100ps

module led_group_pattern_generator_test;
    import lgpg_pkg::*;

    localparam int          N_RAND_PHASES = 11;
    localparam int          TICKS_PER_PHASE = 30;
    localparam int          HOLD_PHASE = 5;      // phase with the long receiver hold-off
    localparam int          PAUSE_PHASE = 9;     // phase with a sender pause mid-way
    localparam int          RX_HOLD_CYCLES = 400;
    localparam int          QUIET_CYCLES = 50;   // covers a no-write tick
    localparam int          STALL_LIMIT = 5000;
    localparam int unsigned TICK_STEP_MS = 10;
    localparam int unsigned MS_CEIL = 20'hFFFFF;
    localparam logic [15:0] NOISE_SEED = 16'hACE1;

    typedef struct packed {
        logic [4:0]  led_index;
        logic [23:0] led_color;
        logic        last;
    } led_write_t;

    // a tick whose writes are typed in by hand: count writes of one colour,
    // indices first, first + dir, ...
    typedef struct {
        bit          fixed;
        int          count;
        logic [23:0] color;
        int          first;
        int          dir;
    } fixed_writes_t;

    typedef struct {
        bit            is_cfg;
        logic [2:0]    cfg_idx;
        logic [23:0]   cfg_val;
        bit            restart;
        fixed_writes_t want;
    } script_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [2:0]             cfg_wr_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // [0] restart, [7:1] zero
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // [4:0] led_index, [28:5] led_color
    logic                   m_tlast;

    // pattern registers as the block holds them
    mode_t       cur_mode = MODE_OFF;
    logic [23:0] lit_rgb = '0;
    logic [5:0]  grp_size = 6'd1;
    logic [19:0] step_ms = '0;
    logic [19:0] hold_ms = '0;
    logic [19:0] flash_offset = '0;
    logic [7:0]  lit_span = '0;
    bit          mirror_on = 1'b0;

    // timing state of the pattern
    logic [19:0] elapsed = '0;
    logic [5:0]  phase = '0;
    bit          bounce_back = 1'b0;
    logic [15:0] noise = NOISE_SEED;

    led_write_t    tick_writes[$];
    led_write_t    led_writes_due[$];
    fixed_writes_t fixed_ticks_due[$];
    script_row_t   script[$];

    int  mismatch_count = 0;
    int  idle_cycles = 0;
    int  tx_gap_pct = 18;
    int  rx_stall_pct = 74;
    bit  rx_hold_req = 1'b0;
    bit  ticks_in_flight = 1'b0;

    led_group_pattern_generator #(
        .MAX_LEDS(32)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Pattern predictor
    // ------------------------------------------------------------------

    function automatic void put_write(input int unsigned idx, input logic [23:0] rgb,
                                      input bit mir, input int unsigned n);
        int unsigned i;
        led_write_t  wr;
        i = mir ? (n - 1 - idx) : idx;
        wr.led_index = i[4:0];
        wr.led_color = rgb;
        wr.last = 1'b0;
        tick_writes.push_back(wr);
    endfunction

    // advance by one tick, saturating at the top of the 20-bit counter
    function automatic void bump_elapsed();
        int unsigned v;
        v = elapsed + TICK_STEP_MS;
        elapsed = (v > MS_CEIL) ? MS_CEIL[19:0] : v[19:0];
    endfunction

    function automatic bit step_due(input int unsigned limit_ms);
        if (elapsed >= limit_ms) begin
            elapsed = '0;
            return 1'b1;
        end
        bump_elapsed();
        return 1'b0;
    endfunction

    // eight shifts of the right-shifting noise register, low byte out
    function automatic int unsigned noise_byte();
        logic fb;
        for (int s = 0; s < 8; s++) begin
            fb = noise[0] ^ noise[2] ^ noise[3] ^ noise[5];
            noise = {fb, noise[15:1]};
        end
        return noise[7:0];
    endfunction

    // work out the LED writes of one tick into tick_writes and move the state on
    function automatic void plan_led_writes(input logic restart);
        int unsigned n, w, pos, r, g, b, on_end, cycle_end;
        bit          mir;
        led_write_t  tail;
        tick_writes.delete();
        n = grp_size;
        if (n < 1) n = 1;
        if (n > 32) n = 32;
        w = (lit_span < n) ? lit_span : n;
        mir = mirror_on;
        if (restart) begin
            elapsed = '0;
            phase = '0;
        end
        case (cur_mode)
            MODE_SOLID: begin
                for (int unsigned k = 0; k < n; k++) put_write(k, lit_rgb, mir, n);
            end
            MODE_FLASH: begin
                on_end = flash_offset + step_ms;
                cycle_end = step_ms + hold_ms;
                if (elapsed >= flash_offset && elapsed < on_end)
                    for (int unsigned k = 0; k < n; k++) put_write(k, lit_rgb, mir, n);
                bump_elapsed();
                if (elapsed >= cycle_end) elapsed = '0;
            end
            MODE_WAVE: begin
                for (int unsigned k = 0; k < w; k++)
                    put_write((phase + k) % n, lit_rgb, mir, n);
                if (step_due(step_ms)) phase = 6'((phase + 1) % n);
            end
            MODE_BOUNCE: begin
                pos = n - w + 1;
                // bounce is never mirrored; drop indices past the end of the group
                for (int unsigned k = 0; k < w; k++)
                    if (phase + k < n) put_write(phase + k, lit_rgb, 1'b0, n);
                if (step_due(step_ms)) begin
                    if (pos <= 1) begin
                        phase = '0;
                    end else if (!bounce_back) begin
                        if (phase + 1 >= pos) begin
                            bounce_back = 1'b1;
                            if (phase > 0) phase--;
                        end else begin
                            phase++;
                        end
                    end else begin
                        if (phase == 0) begin
                            phase = 6'd1;
                            bounce_back = 1'b0;
                        end else begin
                            phase--;
                        end
                    end
                end
            end
            MODE_RANDOM: begin
                if (step_due(step_ms)) begin
                    for (int unsigned k = 0; k < n; k++) begin
                        r = (noise_byte() * lit_span) >> 8;
                        g = (noise_byte() * lit_span) >> 8;
                        b = (noise_byte() * lit_span) >> 8;
                        put_write(k, {r[7:0], g[7:0], b[7:0]}, 1'b0, n);
                    end
                end
            end
            MODE_BAR: begin
                for (int unsigned k = 0; k < w; k++) put_write(k, lit_rgb, mir, n);
            end
            MODE_FILL: begin
                if (phase < n + 1) begin
                    for (int unsigned k = 0; k < phase; k++) put_write(k, lit_rgb, mir, n);
                    if (step_due(step_ms)) phase++;
                end else begin
                    for (int unsigned k = 0; k < n; k++) put_write(k, lit_rgb, mir, n);
                    if (step_due(hold_ms)) phase = '0;
                end
            end
            default: ;
        endcase
        if (tick_writes.size() != 0) begin
            tail = tick_writes.pop_back();
            tail.last = 1'b1;
            tick_writes.push_back(tail);
        end
    endfunction

    function automatic void load_pattern_reg(input logic [2:0] idx, input logic [23:0] val);
        case (idx)
            CFG_MODE:   cur_mode = mode_t'(val[2:0]);
            CFG_COLOR:  lit_rgb = val;
            CFG_GROUP:  grp_size = val[5:0];
            CFG_STEP:   step_ms = val[19:0];
            CFG_HOLD:   hold_ms = val[19:0];
            CFG_OFFSET: flash_offset = val[19:0];
            CFG_SPAN:   lit_span = val[7:0];
            CFG_MIRROR: begin
                mirror_on = val[0];
                bounce_back = val[0];
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check LED writes, predict on every accepted tick, watch for stalls
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : monitor
        led_write_t    want;
        fixed_writes_t chk;
        if (aresetn && m_tvalid && m_tready) begin
            if (led_writes_due.size() == 0) begin
                $error("LED write with nothing expected: index %0d colour %06h last %0b",
                       m_tdata[4:0], m_tdata[28:5], m_tlast);
                mismatch_count++;
            end else begin
                want = led_writes_due.pop_front();
                if (want.led_index !== m_tdata[4:0]) begin
                    $error("led_index: expected %0d, got %0d", want.led_index, m_tdata[4:0]);
                    mismatch_count++;
                end
                if (want.led_color !== m_tdata[28:5]) begin
                    $error("led_color: expected %06h, got %06h",
                           want.led_color, m_tdata[28:5]);
                    mismatch_count++;
                end
                if (want.last !== m_tlast) begin
                    $error("last: expected %0b, got %0b", want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            // always run the predictor so the timing state keeps step
            plan_led_writes(s_tdata[0]);
            chk.fixed = 1'b0;
            if (fixed_ticks_due.size() != 0) chk = fixed_ticks_due.pop_front();
            if (chk.fixed) begin
                // replace the prediction by the hand-written writes
                tick_writes.delete();
                for (int k = 0; k < chk.count; k++) begin
                    want.led_index = 5'(chk.first + chk.dir * k);
                    want.led_color = chk.color;
                    want.last = (k == chk.count - 1);
                    tick_writes.push_back(want);
                end
            end
            foreach (tick_writes[i]) led_writes_due.push_back(tick_writes[i]);
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else idle_cycles++;
    end

    // end the run if no transaction moves for too long
    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus one long hold-off on request
    // ------------------------------------------------------------------

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                // hold off while the sender keeps offering ticks
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // offer one tick and return at the edge where the transaction completes
    task automatic send_tick(input bit restart, input fixed_writes_t want);
        if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_gap_pct);
        end
        fixed_ticks_due.push_back(want);
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_TDATA_W-1){1'b0}}, restart};
        do @(posedge aclk); while (!s_tready);
        ticks_in_flight = 1'b1;
    endtask

    // stop offering and wait until every predicted write has arrived;
    // the first edge lets the monitor log the tick accepted just before
    task automatic drain_led_writes();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (led_writes_due.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
        ticks_in_flight = 1'b0;
    endtask

    // registers change only with the block idle
    task automatic write_pattern_reg(input logic [2:0] idx, input logic [23:0] val);
        if (ticks_in_flight) drain_led_writes();
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        load_pattern_reg(idx, val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Directed script
    // ------------------------------------------------------------------

    function automatic void add_cfg(input logic [2:0] idx, input logic [23:0] val);
        script_row_t row;
        row.is_cfg = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        row.restart = 1'b0;
        row.want.fixed = 1'b0;
        script.push_back(row);
    endfunction

    function automatic void add_tick(input bit restart);
        script_row_t row;
        row.is_cfg = 1'b0;
        row.cfg_idx = CFG_MODE;
        row.cfg_val = '0;
        row.restart = restart;
        row.want.fixed = 1'b0;
        script.push_back(row);
    endfunction

    function automatic void add_fixed(input bit restart, input int count,
                                      input logic [23:0] color, input int first,
                                      input int dir);
        script_row_t row;
        row.is_cfg = 1'b0;
        row.cfg_idx = CFG_MODE;
        row.cfg_val = '0;
        row.restart = restart;
        row.want = '{fixed: 1'b1, count: count, color: color, first: first, dir: dir};
        script.push_back(row);
    endfunction

    function automatic void build_script();
        // off after reset: nothing lit
        add_fixed(0, 0, 24'h0, 0, 1);
        // solid, full group, both colour extremes, then mirrored
        add_cfg(CFG_MODE, {21'd0, MODE_SOLID});
        add_cfg(CFG_COLOR, 24'hFFFFFF);
        add_cfg(CFG_GROUP, 24'd32);
        add_fixed(0, 32, 24'hFFFFFF, 0, 1);
        add_cfg(CFG_MIRROR, 24'd1);
        add_cfg(CFG_COLOR, 24'h000000);
        add_fixed(0, 32, 24'h000000, 31, -1);
        // group size zero is raised to one LED
        add_cfg(CFG_GROUP, 24'd0);
        add_fixed(0, 1, 24'h000000, 0, 1);
        // bar: zero span, span past the count, oversized group capped at 32
        add_cfg(CFG_MODE, {21'd0, MODE_BAR});
        add_cfg(CFG_GROUP, 24'd63);
        add_cfg(CFG_MIRROR, 24'd0);
        add_cfg(CFG_SPAN, 24'd0);
        add_fixed(0, 0, 24'h0, 0, 1);
        add_cfg(CFG_SPAN, 24'd255);
        add_cfg(CFG_COLOR, 24'h5A5A5A);
        add_fixed(0, 32, 24'h5A5A5A, 0, 1);
        add_cfg(CFG_GROUP, 24'd8);
        add_cfg(CFG_SPAN, 24'd5);
        add_cfg(CFG_MIRROR, 24'd1);
        add_fixed(0, 5, 24'h5A5A5A, 7, -1);
        // flash with an offset: dark, lit, lit, wrap and dark again
        add_cfg(CFG_MODE, {21'd0, MODE_FLASH});
        add_cfg(CFG_GROUP, 24'd4);
        add_cfg(CFG_STEP, 24'd20);
        add_cfg(CFG_HOLD, 24'd10);
        add_cfg(CFG_OFFSET, 24'd10);
        add_cfg(CFG_COLOR, 24'h123456);
        add_tick(1);
        add_tick(0);
        add_tick(0);
        add_tick(0);
        // wave stepping every tick, then shrink the group below the phase
        add_cfg(CFG_MODE, {21'd0, MODE_WAVE});
        add_cfg(CFG_GROUP, 24'd5);
        add_cfg(CFG_SPAN, 24'd3);
        add_cfg(CFG_STEP, 24'd0);
        add_cfg(CFG_MIRROR, 24'd0);
        add_tick(1);
        add_tick(0);
        add_tick(0);
        add_cfg(CFG_GROUP, 24'd2);
        add_tick(0);
        // bounce starting backwards, then width equal to the count
        add_cfg(CFG_MODE, {21'd0, MODE_BOUNCE});
        add_cfg(CFG_GROUP, 24'd6);
        add_cfg(CFG_SPAN, 24'd2);
        add_cfg(CFG_STEP, 24'd10);
        add_cfg(CFG_MIRROR, 24'd1);
        add_tick(1);
        add_tick(0);
        add_tick(0);
        add_tick(0);
        add_cfg(CFG_SPAN, 24'd6);
        add_tick(0);
        // random at full intensity, then at zero intensity every channel is dark
        add_cfg(CFG_MODE, {21'd0, MODE_RANDOM});
        add_cfg(CFG_GROUP, 24'd3);
        add_cfg(CFG_SPAN, 24'd255);
        add_cfg(CFG_STEP, 24'd0);
        add_tick(0);
        add_tick(0);
        add_cfg(CFG_SPAN, 24'd0);
        add_fixed(0, 3, 24'h000000, 0, 1);
        // fill up, pause while full, clear
        add_cfg(CFG_MODE, {21'd0, MODE_FILL});
        add_cfg(CFG_GROUP, 24'd2);
        add_cfg(CFG_HOLD, 24'd10);
        add_tick(1);
        add_tick(0);
        add_tick(0);
        add_tick(0);
        add_tick(0);
    endfunction

    // ------------------------------------------------------------------
    // Random settings
    // ------------------------------------------------------------------

    function automatic logic [23:0] random_group();
        case ($urandom_range(19))
            0:       return 24'd0;
            1, 2:    return 24'($urandom_range(33, 63));
            3, 4, 5: return 24'($urandom_range(9, 32));
            default: return 24'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [23:0] random_ms();
        case ($urandom_range(11))
            0:       return 24'd0;
            1:       return 24'hFFFFF;
            2:       return 24'($urandom() & 32'hFFFFF);
            3:       return 24'($urandom_range(0, 60));
            default: return 24'(10 * $urandom_range(0, 6));
        endcase
    endfunction

    function automatic logic [23:0] random_span();
        case ($urandom_range(7))
            0:       return 24'd255;
            1:       return 24'($urandom_range(0, 255));
            2, 3:    return 24'($urandom_range(0, 40));
            default: return 24'($urandom_range(0, 10));
        endcase
    endfunction

    // pick a fresh mode and reshuffle some of the other registers
    task automatic shuffle_pattern(input int ph);
        mode_t m;
        m = mode_t'($urandom_range(7));
        if (ph == HOLD_PHASE) m = MODE_SOLID;
        write_pattern_reg(CFG_MODE, {21'd0, m});
        if (ph == HOLD_PHASE) write_pattern_reg(CFG_GROUP, 24'd16);
        else if ($urandom_range(9) < 6) write_pattern_reg(CFG_GROUP, random_group());
        if ($urandom_range(9) < 6) write_pattern_reg(CFG_COLOR, 24'($urandom()));
        if ($urandom_range(9) < 6) write_pattern_reg(CFG_STEP, random_ms());
        if ($urandom_range(9) < 6) write_pattern_reg(CFG_HOLD, random_ms());
        if ($urandom_range(9) < 6) write_pattern_reg(CFG_OFFSET, random_ms());
        if ($urandom_range(9) < 6) write_pattern_reg(CFG_SPAN, random_span());
        if ($urandom_range(9) < 6) write_pattern_reg(CFG_MIRROR, 24'($urandom_range(1)));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin : main
        fixed_writes_t none;
        none = '{fixed: 1'b0, count: 0, color: 24'h0, first: 0, dir: 1};
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_index <= CFG_MODE;
        cfg_wr_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        build_script();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, first idling regime
        foreach (script[i]) begin
            if (script[i].is_cfg) write_pattern_reg(script[i].cfg_idx, script[i].cfg_val);
            else send_tick(script[i].restart, script[i].want);
        end

        // random part: sender light / receiver heavy, then swapped, then no idling
        for (int ph = 0; ph < N_RAND_PHASES; ph++) begin
            if (ph < 4) begin
                tx_gap_pct = 18;
                rx_stall_pct = 74;
            end else if (ph < 8) begin
                tx_gap_pct = 74;
                rx_stall_pct = 18;
            end else begin
                tx_gap_pct = 0;
                rx_stall_pct = 0;
            end
            ticks_in_flight = 1'b1;
            drain_led_writes();
            shuffle_pattern(ph);
            for (int t = 0; t < TICKS_PER_PHASE; t++) begin
                if (ph == HOLD_PHASE && t == 4) rx_hold_req = 1'b1;
                if (ph == PAUSE_PHASE && t == 15) drain_led_writes();
                send_tick($urandom_range(9) == 0, none);
            end
        end

        drain_led_writes();
        if (mismatch_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/lgpg_pkg.sv
hw/rtl/lgpg_ctrl.sv
hw/rtl/lgpg_dp.sv
hw/rtl/led_group_pattern_generator.sv
tb/led_group_pattern_generator_test.sv
